>>> rtl/core/assert_macros.svh
// Assertion helpers shared by the RTL. Both expect signals named clock and reset in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check, sampled on the rising clock, off during reset.
`define FCT_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error(msg);

// Condition that must never be seen outside reset.
`define FCT_NEVER(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) !(cond)) \
      else $error(msg);

`endif

>>> rtl/core/fct_pkg.sv
`default_nettype none
package fct_pkg;

   localparam int COORD_WIDTH_DEF = 16;
   localparam int NUM_PLANES      = 6;
   localparam int NUM_CORNERS     = 8;
   localparam int NUM_AXES        = 3;
   localparam int COEF_WIDTH      = 16;
   localparam int FRAC_BITS       = 14;
   localparam int KIND_WIDTH      = 2;
   localparam int RES_WIDTH       = 2;
   localparam int CSR_ADDR_WIDTH  = 3;
   localparam int CSR_DATA_WIDTH  = 64;
   localparam int RSP_DATA_WIDTH  = 8;

   // shape kinds
   localparam logic [KIND_WIDTH-1:0] KIND_POINT  = 2'd0;
   localparam logic [KIND_WIDTH-1:0] KIND_SPHERE = 2'd1;
   localparam logic [KIND_WIDTH-1:0] KIND_BOX    = 2'd2;
   localparam logic [KIND_WIDTH-1:0] KIND_RSVD   = 2'd3;

   // containment codes
   localparam logic [RES_WIDTH-1:0] RES_OUTSIDE   = 2'd0;
   localparam logic [RES_WIDTH-1:0] RES_INSIDE    = 2'd1;
   localparam logic [RES_WIDTH-1:0] RES_INTERSECT = 2'd2;

   // one plane register: a in the low 16 bits, d in the top 16 bits
   typedef struct packed {
      logic signed [COEF_WIDTH-1:0] d;
      logic signed [COEF_WIDTH-1:0] c;
      logic signed [COEF_WIDTH-1:0] b;
      logic signed [COEF_WIDTH-1:0] a;
   } plane_type;

   // control carried alongside each pipeline stage
   typedef struct packed {
      logic                  valid;
      logic [KIND_WIDTH-1:0] kind;
   } stage_ctl_type;

endpackage
`default_nettype wire

>>> rtl/core/fct_mul.sv
`default_nettype none
// Stage 1: the 36 coefficient-by-coordinate products (6 planes x 3 axes x min/max).
module fct_mul #(
   parameter int COORD_WIDTH = fct_pkg::COORD_WIDTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  advance,
   input  fct_pkg::stage_ctl_type ctl_up,
   input  logic signed [COORD_WIDTH-1:0] lo_coord [fct_pkg::NUM_AXES],
   input  logic signed [COORD_WIDTH-1:0] hi_coord [fct_pkg::NUM_AXES],
   input  logic        [COORD_WIDTH-2:0] radius_up,
   input  fct_pkg::plane_type    planes [fct_pkg::NUM_PLANES],
   output fct_pkg::stage_ctl_type ctl_dn,
   output logic signed [fct_pkg::COEF_WIDTH+COORD_WIDTH-1:0]
                                 prod_lo [fct_pkg::NUM_PLANES][fct_pkg::NUM_AXES],
   output logic signed [fct_pkg::COEF_WIDTH+COORD_WIDTH-1:0]
                                 prod_hi [fct_pkg::NUM_PLANES][fct_pkg::NUM_AXES],
   output logic signed [fct_pkg::COEF_WIDTH-1:0] offset_dn [fct_pkg::NUM_PLANES],
   output logic        [COORD_WIDTH-2:0] radius_dn
);
   import fct_pkg::*;

   localparam int PROD_WIDTH = COEF_WIDTH + COORD_WIDTH;

   logic signed [COEF_WIDTH-1:0] coef [NUM_PLANES][NUM_AXES];
   logic signed [PROD_WIDTH-1:0] prod_lo_in [NUM_PLANES][NUM_AXES];
   logic signed [PROD_WIDTH-1:0] prod_hi_in [NUM_PLANES][NUM_AXES];
   logic signed [PROD_WIDTH-1:0] prod_lo_ff [NUM_PLANES][NUM_AXES];
   logic signed [PROD_WIDTH-1:0] prod_hi_ff [NUM_PLANES][NUM_AXES];
   logic signed [COEF_WIDTH-1:0] offset_ff [NUM_PLANES];
   logic        [COORD_WIDTH-2:0] radius_ff;
   logic                          valid_ff;
   logic [KIND_WIDTH-1:0]         kind_ff;

   always_comb begin
      for (int p = 0; p < NUM_PLANES; p++) begin
         coef[p][0] = planes[p].a;
         coef[p][1] = planes[p].b;
         coef[p][2] = planes[p].c;
         for (int ax = 0; ax < NUM_AXES; ax++) begin
            prod_lo_in[p][ax] = PROD_WIDTH'(coef[p][ax]) * PROD_WIDTH'(lo_coord[ax]);
            prod_hi_in[p][ax] = PROD_WIDTH'(coef[p][ax]) * PROD_WIDTH'(hi_coord[ax]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= ctl_up.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         kind_ff    <= ctl_up.kind;
         radius_ff  <= radius_up;
         prod_lo_ff <= prod_lo_in;
         prod_hi_ff <= prod_hi_in;
         for (int p = 0; p < NUM_PLANES; p++) begin
            offset_ff[p] <= planes[p].d;
         end
      end
   end

   assign ctl_dn    = '{valid: valid_ff, kind: kind_ff};
   assign prod_lo   = prod_lo_ff;
   assign prod_hi   = prod_hi_ff;
   assign offset_dn = offset_ff;
   assign radius_dn = radius_ff;

endmodule
`default_nettype wire

>>> rtl/core/fct_sum.sv
`default_nettype none
// Stages 2 and 3: partial sums, then the eight corner distances per plane.
module fct_sum #(
   parameter int COORD_WIDTH = fct_pkg::COORD_WIDTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  advance,
   input  fct_pkg::stage_ctl_type ctl_up,
   input  logic signed [fct_pkg::COEF_WIDTH+COORD_WIDTH-1:0]
                                 prod_lo [fct_pkg::NUM_PLANES][fct_pkg::NUM_AXES],
   input  logic signed [fct_pkg::COEF_WIDTH+COORD_WIDTH-1:0]
                                 prod_hi [fct_pkg::NUM_PLANES][fct_pkg::NUM_AXES],
   input  logic signed [fct_pkg::COEF_WIDTH-1:0] offset_up [fct_pkg::NUM_PLANES],
   input  logic        [COORD_WIDTH-2:0] radius_up,
   output fct_pkg::stage_ctl_type ctl_dn,
   output logic signed [fct_pkg::COEF_WIDTH+COORD_WIDTH+1:0]
                                 corner_dist [fct_pkg::NUM_PLANES][fct_pkg::NUM_CORNERS],
   output logic        [COORD_WIDTH-2:0] radius_dn
);
   import fct_pkg::*;

   localparam int PROD_WIDTH = COEF_WIDTH + COORD_WIDTH;
   localparam int PART_WIDTH = PROD_WIDTH + 1;
   localparam int DIST_WIDTH = PROD_WIDTH + 2;
   localparam int XY_COMBOS  = 4;
   localparam int Z_COMBOS   = 2;

   // stage 2: x+y for the four min/max mixes, z+d for the two
   logic signed [PART_WIDTH-1:0] xy_in [NUM_PLANES][XY_COMBOS];
   logic signed [PART_WIDTH-1:0] zd_in [NUM_PLANES][Z_COMBOS];
   logic signed [PART_WIDTH-1:0] xy_ff [NUM_PLANES][XY_COMBOS];
   logic signed [PART_WIDTH-1:0] zd_ff [NUM_PLANES][Z_COMBOS];
   logic        [COORD_WIDTH-2:0] radius2_ff;
   logic                          valid2_ff;
   logic [KIND_WIDTH-1:0]         kind2_ff;

   // stage 3: corner k takes x max on bit 0, y max on bit 1, z max on bit 2
   logic signed [DIST_WIDTH-1:0] dist_in [NUM_PLANES][NUM_CORNERS];
   logic signed [DIST_WIDTH-1:0] dist_ff [NUM_PLANES][NUM_CORNERS];
   logic        [COORD_WIDTH-2:0] radius3_ff;
   logic                          valid3_ff;
   logic [KIND_WIDTH-1:0]         kind3_ff;

   always_comb begin
      for (int p = 0; p < NUM_PLANES; p++) begin
         for (int k = 0; k < XY_COMBOS; k++) begin
            xy_in[p][k] = PART_WIDTH'(((k & 1) != 0) ? prod_hi[p][0] : prod_lo[p][0])
                        + PART_WIDTH'(((k & 2) != 0) ? prod_hi[p][1] : prod_lo[p][1]);
         end
         zd_in[p][0] = PART_WIDTH'(prod_lo[p][2]) + PART_WIDTH'(offset_up[p]);
         zd_in[p][1] = PART_WIDTH'(prod_hi[p][2]) + PART_WIDTH'(offset_up[p]);
      end
   end

   always_comb begin
      for (int p = 0; p < NUM_PLANES; p++) begin
         for (int k = 0; k < NUM_CORNERS; k++) begin
            dist_in[p][k] = DIST_WIDTH'(xy_ff[p][k % XY_COMBOS])
                          + DIST_WIDTH'(zd_ff[p][k / XY_COMBOS]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid2_ff <= 1'b0;
         valid3_ff <= 1'b0;
      end else if (advance) begin
         valid2_ff <= ctl_up.valid;
         valid3_ff <= valid2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         xy_ff      <= xy_in;
         zd_ff      <= zd_in;
         kind2_ff   <= ctl_up.kind;
         radius2_ff <= radius_up;
         dist_ff    <= dist_in;
         kind3_ff   <= kind2_ff;
         radius3_ff <= radius2_ff;
      end
   end

   assign ctl_dn      = '{valid: valid3_ff, kind: kind3_ff};
   assign corner_dist = dist_ff;
   assign radius_dn   = radius3_ff;

endmodule
`default_nettype wire

>>> rtl/core/fct_class.sv
`default_nettype none
// Stage 4: sign and radius tests per plane, reduced to one code, into the output register.
module fct_class #(
   parameter int COORD_WIDTH = fct_pkg::COORD_WIDTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  advance,
   input  fct_pkg::stage_ctl_type ctl_up,
   input  logic signed [fct_pkg::COEF_WIDTH+COORD_WIDTH+1:0]
                                 corner_dist [fct_pkg::NUM_PLANES][fct_pkg::NUM_CORNERS],
   input  logic        [COORD_WIDTH-2:0] radius_up,
   output logic                  rsp_valid,
   output logic [fct_pkg::RES_WIDTH-1:0] containment
);
   import fct_pkg::*;

   localparam int DIST_WIDTH = COEF_WIDTH + COORD_WIDTH + 2;
   localparam int RAD_WIDTH  = COORD_WIDTH - 1 + FRAC_BITS + 1;

   logic signed [DIST_WIDTH-1:0] r_pos;
   logic signed [DIST_WIDTH-1:0] r_neg;
   logic                         point_out;
   logic                         sph_out;
   logic                         sph_cross;
   logic                         box_out;
   logic                         box_cross;
   logic [NUM_CORNERS-1:0]       behind;
   logic [RES_WIDTH-1:0]         containment_in;
   logic                         valid_ff;
   logic [RES_WIDTH-1:0]         containment_ff;

   // radius in distance units (scaled by 2^14), always non-negative
   assign r_pos = DIST_WIDTH'(RAD_WIDTH'({radius_up, {FRAC_BITS{1'b0}}}));
   assign r_neg = -r_pos;

   always_comb begin
      point_out = 1'b0;
      sph_out   = 1'b0;
      sph_cross = 1'b0;
      box_out   = 1'b0;
      box_cross = 1'b0;
      behind    = '0;
      for (int p = 0; p < NUM_PLANES; p++) begin
         for (int k = 0; k < NUM_CORNERS; k++) begin
            behind[k] = corner_dist[p][k][DIST_WIDTH-1];
         end
         // point and sphere use the minimum corner only
         point_out = point_out | behind[0];
         sph_out   = sph_out   | (corner_dist[p][0] < r_neg);
         sph_cross = sph_cross | (corner_dist[p][0] < r_pos);
         box_out   = box_out   | (&behind);
         box_cross = box_cross | ((|behind) & ~(&behind));
      end

      unique case (ctl_up.kind)
         KIND_POINT:  containment_in = point_out ? RES_OUTSIDE : RES_INSIDE;
         KIND_SPHERE: containment_in = sph_out ? RES_OUTSIDE :
                                       (sph_cross ? RES_INTERSECT : RES_INSIDE);
         KIND_BOX:    containment_in = box_out ? RES_OUTSIDE :
                                       (box_cross ? RES_INTERSECT : RES_INSIDE);
         default:     containment_in = RES_OUTSIDE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= ctl_up.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         containment_ff <= containment_in;
      end
   end

   assign rsp_valid   = valid_ff;
   assign containment = containment_ff;

endmodule
`default_nettype wire

>>> rtl/core/frustum_containment_test_unit.sv
`default_nettype none
`include "assert_macros.svh"
// Channel | Dir | Word layout (low bit up)
// --------+-----+----------------------------------------------------------------
// req_    | in  | tdata: pos_x, pos_y, pos_z, radius, box_max_x, box_max_y,
//         |     |        box_max_z, zero pad to bytes; tuser: req_type
// rsp_    | out | tdata: containment, zero pad to 8 bits
// csr_    | in  | write-only, index 0..5 = left, right, top, bottom, near, far
//
// One word per cycle sustained while rsp_tready stays high; each word accepted on req passes
// through multiply, partial sum, corner sum, classify into the output register.
// All four stages move together; a held rsp word (tready low) freezes every stage,
// and req_tready drops with it. Bubbles advance whenever the output moves.
// Synchronous reset clears all stage valid bits and the six plane registers.
module frustum_containment_test_unit #(
   parameter int COORD_WIDTH = fct_pkg::COORD_WIDTH_DEF,
   localparam int REQ_DATA_WIDTH = ((7 * COORD_WIDTH - 1 + 7) / 8) * 8
) (
   input  logic                                clock,
   input  logic                                reset,
   // input stream
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [REQ_DATA_WIDTH-1:0]           req_tdata,  // pos_x,pos_y,pos_z,radius,box_max_x/y/z
   input  logic [fct_pkg::KIND_WIDTH-1:0]      req_tuser,  // req_type
   // result stream
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [fct_pkg::RSP_DATA_WIDTH-1:0]  rsp_tdata,  // containment
   // plane registers
   input  logic                                csr_we,
   input  logic [fct_pkg::CSR_ADDR_WIDTH-1:0]  csr_addr,
   input  logic [fct_pkg::CSR_DATA_WIDTH-1:0]  csr_wdata
);
   import fct_pkg::*;

   localparam int PROD_WIDTH = COEF_WIDTH + COORD_WIDTH;
   localparam int DIST_WIDTH = PROD_WIDTH + 2;
   localparam int RADIUS_LSB = NUM_AXES * COORD_WIDTH;
   localparam int HI_LSB     = RADIUS_LSB + COORD_WIDTH - 1;

   plane_type                    plane_ff [NUM_PLANES];
   logic                         advance;
   stage_ctl_type                s0_ctl;
   stage_ctl_type                s1_ctl;
   stage_ctl_type                s3_ctl;
   logic signed [COORD_WIDTH-1:0] lo_coord [NUM_AXES];
   logic signed [COORD_WIDTH-1:0] hi_coord [NUM_AXES];
   logic        [COORD_WIDTH-2:0] radius_s0;
   logic        [COORD_WIDTH-2:0] radius_s1;
   logic        [COORD_WIDTH-2:0] radius_s3;
   logic signed [PROD_WIDTH-1:0] prod_lo [NUM_PLANES][NUM_AXES];
   logic signed [PROD_WIDTH-1:0] prod_hi [NUM_PLANES][NUM_AXES];
   logic signed [COEF_WIDTH-1:0] offset_s1 [NUM_PLANES];
   logic signed [DIST_WIDTH-1:0] corner_dist [NUM_PLANES][NUM_CORNERS];
   logic [RES_WIDTH-1:0]         containment;

   // plane registers; writes past the last index are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int p = 0; p < NUM_PLANES; p++) begin
            plane_ff[p] <= '0;
         end
      end else if (csr_we && (csr_addr < CSR_ADDR_WIDTH'(NUM_PLANES))) begin
         plane_ff[csr_addr] <= csr_wdata;
      end
   end

   // whole pipe moves when the output register is empty or being drained
   assign advance    = !rsp_tvalid || rsp_tready;
   assign req_tready = advance;

   // unpack the request word
   assign s0_ctl    = '{valid: req_tvalid, kind: req_tuser};
   assign radius_s0 = req_tdata[RADIUS_LSB +: COORD_WIDTH-1];
   always_comb begin
      for (int ax = 0; ax < NUM_AXES; ax++) begin
         lo_coord[ax] = req_tdata[ax * COORD_WIDTH +: COORD_WIDTH];
         hi_coord[ax] = req_tdata[HI_LSB + ax * COORD_WIDTH +: COORD_WIDTH];
      end
   end

   fct_mul #(.COORD_WIDTH(COORD_WIDTH)) u_mul (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .ctl_up    (s0_ctl),
      .lo_coord  (lo_coord),
      .hi_coord  (hi_coord),
      .radius_up (radius_s0),
      .planes    (plane_ff),
      .ctl_dn    (s1_ctl),
      .prod_lo   (prod_lo),
      .prod_hi   (prod_hi),
      .offset_dn (offset_s1),
      .radius_dn (radius_s1)
   );

   fct_sum #(.COORD_WIDTH(COORD_WIDTH)) u_sum (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .ctl_up      (s1_ctl),
      .prod_lo     (prod_lo),
      .prod_hi     (prod_hi),
      .offset_up   (offset_s1),
      .radius_up   (radius_s1),
      .ctl_dn      (s3_ctl),
      .corner_dist (corner_dist),
      .radius_dn   (radius_s3)
   );

   fct_class #(.COORD_WIDTH(COORD_WIDTH)) u_class (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .ctl_up      (s3_ctl),
      .corner_dist (corner_dist),
      .radius_up   (radius_s3),
      .rsp_valid   (rsp_tvalid),
      .containment (containment)
   );

   assign rsp_tdata = RSP_DATA_WIDTH'(containment);

   // a word accepted while the pipe keeps advancing through every stage has reached the output
   `FCT_ASSERT(a_latency, (req_tvalid && req_tready) ##1 advance ##1 advance ##1 advance |=> rsp_tvalid, "accepted word did not reach output in 4 cycles")
   // the unused selector must classify as outside
   `FCT_ASSERT(a_rsvd_kind, (s3_ctl.valid && advance && s3_ctl.kind == KIND_RSVD) |=> (containment == RES_OUTSIDE), "reserved kind not outside")
   // only three codes exist on the result
   `FCT_NEVER(a_res_code, rsp_tvalid && containment != RES_OUTSIDE && containment != RES_INSIDE && containment != RES_INTERSECT, "bad containment code")

endmodule
`default_nettype wire

>>> dv/tb_frustum_containment_test_unit.sv
`timescale 1ns / 100ps
module tb_frustum_containment_test_unit;
   import fct_pkg::*;

   // ---------------------------------------------------------------------
   // Geometry of the words
   // ---------------------------------------------------------------------
   localparam int CW    = COORD_WIDTH_DEF;
   localparam int REQ_W = ((7 * CW - 1 + 7) / 8) * 8;
   localparam int FULL_SPAN = (1 << (CW - 1)) - 1;

   // pipeline depth from the header of the block, plus some margin for settling
   localparam int FLIGHT_CYCLES = 4;
   localparam int SETTLE_CYCLES = FLIGHT_CYCLES + 4;

   localparam int MAX_REPORTS = 10;
   localparam int PHASE_ITEMS = 180;
   localparam int NUM_PHASES  = 6;

   // plane register map
   localparam logic [CSR_ADDR_WIDTH-1:0] REG_LEFT    = 3'd0;
   localparam logic [CSR_ADDR_WIDTH-1:0] REG_RIGHT   = 3'd1;
   localparam logic [CSR_ADDR_WIDTH-1:0] REG_TOP     = 3'd2;
   localparam logic [CSR_ADDR_WIDTH-1:0] REG_BOTTOM  = 3'd3;
   localparam logic [CSR_ADDR_WIDTH-1:0] REG_NEAR    = 3'd4;
   localparam logic [CSR_ADDR_WIDTH-1:0] REG_FAR     = 3'd5;
   // indexes past the plane set; writes there must change nothing
   localparam logic [CSR_ADDR_WIDTH-1:0] REG_SPARE_A = 3'd6;
   localparam logic [CSR_ADDR_WIDTH-1:0] REG_SPARE_B = 3'd7;

   localparam logic [CSR_ADDR_WIDTH-1:0] PLANE_REG [NUM_PLANES] =
      '{REG_LEFT, REG_RIGHT, REG_TOP, REG_BOTTOM, REG_NEAR, REG_FAR};

   // unit cube |x|,|y|,|z| <= 1; word layout {d, c, b, a}
   localparam logic [CSR_DATA_WIDTH-1:0] CUBE_PLANE [NUM_PLANES] = '{
      64'h4000_0000_0000_4000,   // x >= -1
      64'h4000_0000_0000_C000,   // x <= 1
      64'h4000_0000_C000_0000,   // y <= 1
      64'h4000_0000_4000_0000,   // y >= -1
      64'h4000_4000_0000_0000,   // z >= -1
      64'h4000_C000_0000_0000    // z <= 1
   };

   typedef enum int {
      STYLE_RESET,      // leave the registers as reset left them
      STYLE_CUBE,       // small axis-aligned box frustum
      STYLE_EXTREME,    // every coefficient at a rail or at 0 / -1
      STYLE_SHALLOW,    // small normals, mostly positive offsets: mixed outcomes
      STYLE_FULL        // every bit random
   } plane_style_type;

   typedef struct {
      logic [KIND_WIDTH-1:0] kind;
      logic signed [CW-1:0]  x, y, z;
      logic [CW-2:0]         rad;
      logic signed [CW-1:0]  mx, my, mz;
   } shape_type;

   typedef struct {
      plane_style_type       style;
      shape_type             shp;
      bit                    typed;
      logic [RES_WIDTH-1:0]  want;
   } directed_row_type;

   typedef struct {
      logic [RES_WIDTH-1:0] cls;
      int                   tag;
   } pending_cls_type;

   // ---------------------------------------------------------------------
   // DUT hookup
   // ---------------------------------------------------------------------
   logic                       clock = 1'b0;
   logic                       reset;
   logic                       req_tvalid;
   logic                       req_tready;
   logic [REQ_W-1:0]           req_tdata;
   logic [KIND_WIDTH-1:0]      req_tuser;
   logic                       rsp_tvalid;
   logic                       rsp_tready = 1'b0;
   logic [RSP_DATA_WIDTH-1:0]  rsp_tdata;
   logic                       csr_we;
   logic [CSR_ADDR_WIDTH-1:0]  csr_addr;
   logic [CSR_DATA_WIDTH-1:0]  csr_wdata;

   frustum_containment_test_unit #(.COORD_WIDTH(CW)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),    // pos_x, pos_y, pos_z, radius, box_max_x/y/z, pad
      .req_tuser  (req_tuser),    // req_type
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),    // containment, pad
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // Shared state
   // ---------------------------------------------------------------------
   plane_type        plane_shadow [NUM_PLANES];   // what the plane registers should hold
   pending_cls_type  pending [$];                 // containment codes still owed, oldest first
   directed_row_type dir_tab [$];
   int               mismatches = 0;
   int               words_sent = 0;
   int               send_gap_pct = 0;            // chance of an idle cycle before each req word
   int               sink_stall_pct = 0;          // chance of rsp_tready low in a cycle

   // ---------------------------------------------------------------------
   // Predictor: signed plane distances at full precision, then classify
   // ---------------------------------------------------------------------
   function automatic longint plane_distance(int p, longint x, longint y, longint z);
      plane_type pl;
      pl = plane_shadow[p];
      return longint'($signed(pl.a)) * x + longint'($signed(pl.b)) * y
           + longint'($signed(pl.c)) * z + longint'($signed(pl.d));
   endfunction

   function automatic logic [RES_WIDTH-1:0] classify_shape(shape_type s);
      longint lo [3];
      longint hi [3];
      longint rad, pdist, cx, cy, cz;
      bit     outside, straddle;
      int     behind;
      outside  = 1'b0;
      straddle = 1'b0;
      lo[0] = s.x;   lo[1] = s.y;   lo[2] = s.z;
      hi[0] = s.mx;  hi[1] = s.my;  hi[2] = s.mz;
      rad = longint'(s.rad) << FRAC_BITS;
      case (s.kind)
         KIND_POINT: begin
            for (int p = 0; p < NUM_PLANES; p++)
               if (plane_distance(p, lo[0], lo[1], lo[2]) < 0) outside = 1'b1;
         end
         KIND_SPHERE: begin
            for (int p = 0; p < NUM_PLANES; p++) begin
               pdist = plane_distance(p, lo[0], lo[1], lo[2]);
               if (pdist < -rad) outside = 1'b1;
               else if (pdist < rad) straddle = 1'b1;
            end
         end
         KIND_BOX: begin
            // corners come straight from min/max, even when a box is inverted
            for (int p = 0; p < NUM_PLANES; p++) begin
               behind = 0;
               for (int k = 0; k < NUM_CORNERS; k++) begin
                  cx = (k & 1) ? hi[0] : lo[0];
                  cy = (k & 2) ? hi[1] : lo[1];
                  cz = (k & 4) ? hi[2] : lo[2];
                  if (plane_distance(p, cx, cy, cz) < 0) behind++;
               end
               if (behind == NUM_CORNERS) outside = 1'b1;
               else if (behind != 0) straddle = 1'b1;
            end
         end
         default: return RES_OUTSIDE;   // unused selector
      endcase
      if (outside) return RES_OUTSIDE;
      if (straddle) return RES_INTERSECT;
      return RES_INSIDE;
   endfunction

   // ---------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------
   function automatic void table_row(plane_style_type style, logic [KIND_WIDTH-1:0] kind,
                                     int x, int y, int z, int r, int mx, int my, int mz,
                                     bit typed, logic [RES_WIDTH-1:0] want);
      directed_row_type row;
      row.style     = style;
      row.shp.kind  = kind;
      row.shp.x     = CW'(x);
      row.shp.y     = CW'(y);
      row.shp.z     = CW'(z);
      row.shp.rad   = (CW-1)'(r);
      row.shp.mx    = CW'(mx);
      row.shp.my    = CW'(my);
      row.shp.mz    = CW'(mz);
      row.typed     = typed;
      row.want      = want;
      dir_tab.push_back(row);
   endfunction

   function automatic logic [COEF_WIDTH-1:0] rail_coef();
      case ($urandom_range(0, 3))
         0:       return 16'h8000;
         1:       return 16'h7FFF;
         2:       return 16'h0000;
         default: return 16'hFFFF;
      endcase
   endfunction

   function automatic logic [CSR_DATA_WIDTH-1:0] pick_plane(plane_style_type style, int p);
      plane_type pl;
      case (style)
         STYLE_CUBE:    return CUBE_PLANE[p];
         STYLE_EXTREME: return {rail_coef(), rail_coef(), rail_coef(), rail_coef()};
         STYLE_SHALLOW: begin
            pl.a = COEF_WIDTH'(int'($urandom_range(0, 400)) - 200);
            pl.b = COEF_WIDTH'(int'($urandom_range(0, 400)) - 200);
            pl.c = COEF_WIDTH'(int'($urandom_range(0, 400)) - 200);
            // mostly the origin sits in front, now and then behind
            pl.d = ($urandom_range(0, 9) == 0) ? COEF_WIDTH'(-int'($urandom_range(0, 4000)))
                                              : COEF_WIDTH'($urandom_range(0, 32767));
            return pl;
         end
         default:       return {$urandom, $urandom};
      endcase
   endfunction

   // coordinate in [-span, span], or any 16-bit value for the full span
   function automatic logic signed [CW-1:0] pick_coord(int span);
      if (span >= FULL_SPAN) return CW'($urandom);
      return CW'(int'($urandom_range(0, 2 * span)) - span);
   endfunction

   // box max: usually min plus an extent of at most span, sometimes unrelated (may invert)
   function automatic logic signed [CW-1:0] pick_box_max(logic signed [CW-1:0] lo, int span);
      int v;
      if ($urandom_range(0, 99) < 15) return pick_coord(span);
      v = int'(lo) + int'($urandom_range(0, span));
      if (v > FULL_SPAN) v = FULL_SPAN;
      return CW'(v);
   endfunction

   function automatic shape_type random_shape();
      shape_type s;
      int        span;
      case ($urandom_range(0, 3))
         0:       span = FULL_SPAN;
         1:       span = 4;
         2:       span = 40;
         default: span = 300;
      endcase
      s.kind = ($urandom_range(0, 99) < 4) ? KIND_RSVD : KIND_WIDTH'($urandom_range(0, 2));
      s.x = pick_coord(span);
      s.y = pick_coord(span);
      s.z = pick_coord(span);
      if (s.kind == KIND_SPHERE && span < FULL_SPAN)
         s.rad = (CW-1)'($urandom_range(0, span + 2));
      else
         s.rad = (CW-1)'($urandom);
      if (s.kind == KIND_BOX) begin
         s.mx = pick_box_max(s.x, span);
         s.my = pick_box_max(s.y, span);
         s.mz = pick_box_max(s.z, span);
      end else begin
         // don't-care fields still get random content
         s.mx = CW'($urandom);
         s.my = CW'($urandom);
         s.mz = CW'($urandom);
      end
      return s;
   endfunction

   // ---------------------------------------------------------------------
   // Bus tasks
   // ---------------------------------------------------------------------
   task automatic csr_write(logic [CSR_ADDR_WIDTH-1:0] idx, logic [CSR_DATA_WIDTH-1:0] val);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= val;
      @(posedge clock);
      if (idx < NUM_PLANES) plane_shadow[idx] = val;
   endtask

   task automatic load_planes(plane_style_type style, bit poke_spares);
      if (style != STYLE_RESET) begin
         for (int p = 0; p < NUM_PLANES; p++)
            csr_write(PLANE_REG[p], pick_plane(style, p));
         if (poke_spares) begin
            csr_write(REG_SPARE_A, '1);
            csr_write(REG_SPARE_B, {$urandom, $urandom});
         end
         csr_we <= 1'b0;
      end
   endtask

   // hand one word to the block; the expectation is queued at the accepting edge
   task automatic push_shape(shape_type s, bit typed, logic [RES_WIDTH-1:0] want);
      pending_cls_type e;
      while ($urandom_range(0, 99) < send_gap_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= s.kind;
      req_tdata  <= REQ_W'({s.mz, s.my, s.mx, s.rad, s.z, s.y, s.x});
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      e.cls = typed ? want : classify_shape(s);
      e.tag = words_sent;
      pending.push_back(e);
      words_sent++;
   endtask

   // registers are only touched once the pipe has emptied
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (pending.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic flag_mismatch(string msg);
      mismatches++;
      if (mismatches <= MAX_REPORTS) $display("%s", msg);
   endtask

   // ---------------------------------------------------------------------
   // Result side: random back-pressure and the scoreboard
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
   end

   always @(posedge clock) begin : watch_rsp
      pending_cls_type head;
      logic [RSP_DATA_WIDTH-1:0] want_word;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending.size() == 0) begin
            flag_mismatch($sformatf("%0t: rsp word 0x%02h with nothing outstanding",
                                    $realtime, rsp_tdata));
         end else begin
            head = pending.pop_front();
            want_word = RSP_DATA_WIDTH'(head.cls);   // pad bits must read zero
            if (rsp_tdata !== want_word)
               flag_mismatch($sformatf("%0t: word %0d containment exp 0x%02h got 0x%02h",
                                       $realtime, head.tag, want_word, rsp_tdata));
         end
      end
   end

   // ---------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------
   initial begin
      plane_style_type cur_style;
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tuser  <= KIND_POINT;
      csr_we     <= 1'b0;
      csr_addr   <= REG_LEFT;
      csr_wdata  <= '0;
      for (int p = 0; p < NUM_PLANES; p++) plane_shadow[p] = '0;

      // Directed table. With reset planes every distance is exactly 0, which is
      // not behind: points and boxes are inside, a sphere straddles iff r > 0.
      table_row(STYLE_RESET, KIND_POINT,       0,      0,      0,     0,      0,     0,     0,
                1, RES_INSIDE);
      table_row(STYLE_RESET, KIND_POINT,  -32768,  32767, -32768, 32767,  32767, -32768, 32767,
                1, RES_INSIDE);
      table_row(STYLE_RESET, KIND_SPHERE,      5,      5,      5,     0,      0,     0,     0,
                1, RES_INSIDE);
      table_row(STYLE_RESET, KIND_SPHERE, -32768, -32768, -32768, 32767,      0,     0,     0,
                1, RES_INTERSECT);
      table_row(STYLE_RESET, KIND_BOX,         0,      0,      0,     0,      0,     0,     0,
                1, RES_INSIDE);
      table_row(STYLE_RESET, KIND_BOX,    -32768, -32768, -32768, 32767,  32767, 32767, 32767,
                1, RES_INSIDE);
      table_row(STYLE_RESET, KIND_RSVD,        0,      0,      0,     0,      0,     0,     0,
                1, RES_OUTSIDE);
      // unit cube frustum: boundary hits, radius ties, inverted boxes
      table_row(STYLE_CUBE, KIND_POINT,        0,      0,      0,     0,      0,     0,     0,
                0, RES_OUTSIDE);
      table_row(STYLE_CUBE, KIND_POINT,        1,      1,      1,     0,      0,     0,     0,
                0, RES_OUTSIDE);
      table_row(STYLE_CUBE, KIND_POINT,        2,      0,      0,     0,      0,     0,     0,
                0, RES_OUTSIDE);
      table_row(STYLE_CUBE, KIND_POINT,    32767, -32768,  32767,     0,      0,     0,     0,
                0, RES_OUTSIDE);
      table_row(STYLE_CUBE, KIND_SPHERE,       0,      0,      0,     1,      0,     0,     0,
                0, RES_OUTSIDE);
      table_row(STYLE_CUBE, KIND_SPHERE,       0,      0,      0,     2,      0,     0,     0,
                0, RES_OUTSIDE);
      table_row(STYLE_CUBE, KIND_SPHERE,       3,      0,      0,     2,      0,     0,     0,
                0, RES_OUTSIDE);
      table_row(STYLE_CUBE, KIND_SPHERE,       5,      0,      0,     3,      0,     0,     0,
                0, RES_OUTSIDE);
      table_row(STYLE_CUBE, KIND_SPHERE,  -32768, -32768, -32768, 32767,      0,     0,     0,
                0, RES_OUTSIDE);
      table_row(STYLE_CUBE, KIND_BOX,         -1,     -1,     -1,     0,      1,     1,     1,
                0, RES_OUTSIDE);
      table_row(STYLE_CUBE, KIND_BOX,          0,      0,      0,     0,      5,     5,     5,
                0, RES_OUTSIDE);
      table_row(STYLE_CUBE, KIND_BOX,          3,      3,      3,     0,      5,     5,     5,
                0, RES_OUTSIDE);
      table_row(STYLE_CUBE, KIND_BOX,          1,      1,      1,     0,     -1,    -1,    -1,
                0, RES_OUTSIDE);
      table_row(STYLE_CUBE, KIND_BOX,          5,      0,      0,     0,     -5,     0,     0,
                0, RES_OUTSIDE);
      table_row(STYLE_CUBE, KIND_RSVD,         0,      0,      0,     9,      1,     1,     1,
                1, RES_OUTSIDE);
      // coefficients on the rails against coordinates on the rails
      table_row(STYLE_EXTREME, KIND_POINT,  32767,  32767,  32767,    0,      0,     0,     0,
                0, RES_OUTSIDE);
      table_row(STYLE_EXTREME, KIND_BOX,   -32768, -32768, -32768,    0,  32767, 32767, 32767,
                0, RES_OUTSIDE);
      table_row(STYLE_EXTREME, KIND_SPHERE, -32768, 32767, -32768, 32767,     0,     0,     0,
                0, RES_OUTSIDE);

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      send_gap_pct   = 31;
      sink_stall_pct = 72;
      cur_style      = STYLE_RESET;
      foreach (dir_tab[i]) begin
         if (dir_tab[i].style != cur_style) begin
            wait_drained();
            cur_style = dir_tab[i].style;
            load_planes(cur_style, 1'b0);
         end
         push_shape(dir_tab[i].shp, dir_tab[i].typed, dir_tab[i].want);
      end

      // Random phases: a fresh plane set each time; idling pattern moves from
      // slow sender / slow sink, to the reverse, to full rate both ways.
      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         wait_drained();
         case (ph / 2)
            0: begin send_gap_pct = 31; sink_stall_pct = 72; end
            1: begin send_gap_pct = 72; sink_stall_pct = 31; end
            default: begin send_gap_pct = 0; sink_stall_pct = 0; end
         endcase
         case (ph)
            0, 3:    cur_style = STYLE_SHALLOW;
            1, 5:    cur_style = STYLE_FULL;
            2:       cur_style = STYLE_EXTREME;
            default: cur_style = STYLE_CUBE;
         endcase
         load_planes(cur_style, ph == 0);
         for (int n = 0; n < PHASE_ITEMS; n++)
            push_shape(random_shape(), 1'b0, RES_OUTSIDE);
      end

      // let stray words show up after the last expected one
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatches == 0 && pending.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   // this timeout is far beyond the length of any legal run
   initial begin
      #2000000;
      $display("Some tests failed");
      $finish;
   end

endmodule
